@@ rtl/core/framed_word_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// Framed word receiver assertion macros
// Shared property wrappers for the port checker of the receiver.
// ----------------------------------------------------------------------------
`ifndef FRAMED_WORD_RECEIVER_MACROS_SVH
`define FRAMED_WORD_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWR_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("framed_word_receiver check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FWR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("framed_word_receiver check failed");

`endif

@@ rtl/core/fwr_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed word receiver package
// Constants and the push record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package fwr_pkg;

  localparam logic [7:0] START_MARK = 8'hAA;

  typedef struct packed {
    logic       valid;
    logic       has_word;
    logic [3:0] word_index;
    logic       last;
  } push_t;

endpackage

@@ rtl/core/framed_word_receiver.sv @@
// ----------------------------------------------------------------------------
// Framed word receiver
// Parses 0xAA/id/length/data/checksum frames and returns 16-bit data words.
// ----------------------------------------------------------------------------
// Usage: bytes enter on in_rx_byte with in_valid; the block raises in_stall
// only while it drains an accepted frame. On the checksum byte of a frame
// whose XOR checksum and id match cfg_wr_data's last value (device id, 2
// after reset), the block stalls input and emits one item per word, high
// byte first, through its single store read port: each word is read in
// S_FETCH and pushed in S_EMIT, which waits while out_stall holds the output.
// A frame with fewer than two data bytes yields one item with out_has_word
// low and out_last high; a bad frame yields nothing. out_last marks the final
// item of a frame. Results sit in an output register, so bytes keep flowing
// after the last word is queued even while out_stall is high. Synchronous
// reset returns the parser to hunting for a start byte and empties the output
// register; the data store is not cleared. The user must write configuration
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module framed_word_receiver #(
  parameter int RX_WORDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_has_word,
  output logic [3:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int AW = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;

  fwr_pkg::push_t push;
  logic           out_free;
  logic           wr_en;
  logic           wr_odd;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [15:0]    rd_data;

  logic               out_valid_r;
  logic               out_has_word_r;
  logic [3:0]         out_word_index_r;
  logic signed [15:0] out_word_value_r;
  logic               out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  fwr_seq #(
    .RX_WORDS (RX_WORDS),
    .AW       (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_byte     (in_rx_byte),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_free    (out_free),
    .wr_en       (wr_en),
    .wr_odd      (wr_odd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .push        (push)
  );

  fwr_store #(
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_odd  (wr_odd),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_has_word_r   <= push.has_word;
      out_word_index_r <= push.word_index;
      out_word_value_r <= push.has_word ? $signed(rd_data) : 16'sd0;
      out_last_r       <= push.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_word   = out_has_word_r;
  assign out_word_index = out_word_index_r;
  assign out_word_value = out_word_value_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/core/fwr_store.sv @@
// ----------------------------------------------------------------------------
// Frame data store
// Two byte banks (high and low byte of each word) with a registered word read.
// ----------------------------------------------------------------------------
module fwr_store #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_odd,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  localparam int Depth = 1 << AW;

  logic [7:0]  mem_hi [Depth];
  logic [7:0]  mem_lo [Depth];
  logic [15:0] rd_data_r;

  // Even data bytes go to the high bank, odd bytes to the low bank.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_odd) begin
        mem_lo[wr_addr] <= wr_data;
      end else begin
        mem_hi[wr_addr] <= wr_data;
      end
    end
    rd_data_r <= {mem_hi[rd_addr], mem_lo[rd_addr]};
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/fwr_seq.sv @@
// ----------------------------------------------------------------------------
// Frame parsing sequencer
// Walks the frame byte by byte through one shared XOR unit and drains words.
// ----------------------------------------------------------------------------
module fwr_seq #(
  parameter int RX_WORDS = 16,
  parameter int AW       = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_stall,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  input  logic           out_free,
  output logic           wr_en,
  output logic           wr_odd,
  output logic [AW-1:0]  wr_addr,
  output logic [AW-1:0]  rd_addr,
  output fwr_pkg::push_t push
);

  localparam logic [8:0] StoreLim = 9'(2 * RX_WORDS);

  typedef enum logic [2:0] {
    S_HUNT, S_ID, S_LEN, S_DATA, S_CHECK, S_FETCH, S_EMIT, S_MARK
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    dev_r;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic       accept;
  logic [7:0] xor_opnd;
  logic [7:0] xor_res;
  logic [7:0] pos_inc;
  logic [6:0] words;
  logic [6:0] idx_ext;
  logic       is_last;
  logic       check_ok;

  assign in_stall = (state_r == S_FETCH) || (state_r == S_EMIT) || (state_r == S_MARK);
  assign accept   = in_valid && !in_stall;

  // The one XOR unit both accumulates the checksum and compares against it.
  assign xor_opnd = (state_r == S_ID) ? 8'd0 : xor_r;
  assign xor_res  = xor_opnd ^ in_byte;
  assign check_ok = (xor_res == 8'd0) && (id_r == dev_r);

  assign pos_inc = pos_r + 8'd1;
  assign words   = len_r[7:1];
  assign idx_ext = 7'(idx_r);
  assign is_last = (idx_ext + 7'd1) == words;

  assign wr_en   = accept && (state_r == S_DATA);
  assign wr_odd  = pos_r[0];
  assign wr_addr = pos_r[AW:1];
  assign rd_addr = idx_r;

  always_comb begin
    push.valid      = ((state_r == S_EMIT) || (state_r == S_MARK)) && out_free;
    push.has_word   = (state_r == S_EMIT);
    push.word_index = (state_r == S_EMIT) ? idx_ext[3:0] : 4'd0;
    push.last       = (state_r == S_MARK) ? 1'b1 : is_last;
  end

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_HUNT: begin
        if (accept && (in_byte == fwr_pkg::START_MARK)) begin
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        if (accept) begin
          id_nxt    = in_byte;
          xor_nxt   = xor_res;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          len_nxt = in_byte;
          xor_nxt = xor_res;
          pos_nxt = 8'd0;
          priority if ({1'b0, in_byte} > StoreLim) begin
            state_nxt = S_HUNT;
          end else if (in_byte == 8'd0) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          xor_nxt = xor_res;
          pos_nxt = pos_inc;
          if (pos_inc >= len_r) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (accept) begin
          idx_nxt = '0;
          priority if (!check_ok) begin
            state_nxt = S_HUNT;
          end else if (words == 7'd0) begin
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // Read address settles this cycle; the word is registered for S_EMIT.
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = S_HUNT;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          state_nxt = S_HUNT;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      dev_r   <= 8'd2;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      pos_r   <= 8'd0;
      xor_r   <= 8'd0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) begin
        dev_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ rtl/core/fwr_checker.sv @@
// ----------------------------------------------------------------------------
// Framed word receiver port checker
// Watches the top-level ports for result and drain consistency.
// ----------------------------------------------------------------------------
`include "framed_word_receiver_macros.svh"

module fwr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_has_word,
  input logic [3:0]         out_word_index,
  input logic signed [15:0] out_word_value,
  input logic               out_last
);

  // A stalled result item stays in place.
  `FWR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_word_value) && $stable(out_word_index)
                   && $stable(out_last))

  // The empty-frame marker is always a lone, zeroed, final item.
  `FWR_ASSERT_NOW(a_marker_form, out_valid && !out_has_word,
                  out_last && (out_word_index == 4'd0) && (out_word_value == 16'sd0))

  // While words of a frame remain, the input side is held off.
  `FWR_ASSERT_NOW(a_drain_stalls, out_valid && !out_last, in_stall)

endmodule

bind framed_word_receiver fwr_checker u_fwr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_has_word   (out_has_word),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value),
  .out_last       (out_last)
);
